// File: rtl/tsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    // Request commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
    } t_rsp;

    // Stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

`default_nettype wire

// File: rtl/two_stack_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// First-in first-out queue built from two stacks of STACK_DEPTH entries each.
// A request is taken when start is high and busy is low; its result appears
// on o_rsp with o_done high for exactly one cycle and cannot be stalled.
// A push, and a pop on an empty queue, leave busy low, so such requests may
// follow every cycle; the registered result comes in the next cycle.
// A pop served from a non-empty output stack holds busy for one cycle (one
// registered memory read). A pop that finds the output stack empty first moves
// the n entries of the input stack across, one entry per cycle through a
// single read-then-write path, and holds busy until its result is registered.
// Each entry is moved once. A push to a full input stack is dropped with
// status full; no clearing pass is needed after reset.
module two_stack_queue
    import tsq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    t_stk_ctl                 in_ctl, out_ctl;
    logic [CNT_W-1:0]         in_count, out_count;
    logic signed [DATA_W-1:0] in_wdata, out_wdata;
    logic signed [DATA_W-1:0] in_rdata, out_rdata;

    // Sequencer
    tsq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_in_count  (in_count),
        .i_out_count (out_count),
        .i_in_rdata  (in_rdata),
        .i_out_rdata (out_rdata),
        .o_in_ctl    (in_ctl),
        .o_out_ctl   (out_ctl),
        .o_in_wdata  (in_wdata),
        .o_out_wdata (out_wdata),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    // Input stack
    tsq_stack u_in_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_wdata (in_wdata),
        .o_count (in_count),
        .o_rdata (in_rdata)
    );

    // Output stack
    tsq_stack u_out_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (out_ctl),
        .i_wdata (out_wdata),
        .o_count (out_count),
        .o_rdata (out_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/tsq_stack.sv
`timescale 1ns / 1ps
`default_nettype none

module tsq_stack
    import tsq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_stk_ctl                 i_ctl,
    input  wire logic signed [DATA_W-1:0] i_wdata,
    output logic [CNT_W-1:0]              o_count,
    output logic signed [DATA_W-1:0]      o_rdata
);

    logic signed [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         top_cnt;

    // Index of the top entry
    assign top_cnt = r_count - CNT_W'(1);

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_count <= top_cnt;
        end
    end

    // Storage: write at count, registered read of the top on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_wdata;
        end
        if (i_ctl.pop) begin
            o_rdata <= r_mem[top_cnt[IDX_W-1:0]];
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// File: rtl/tsq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tsq_seq
    import tsq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_req                     i_req,
    input  wire logic [CNT_W-1:0]         i_in_count,
    input  wire logic [CNT_W-1:0]         i_out_count,
    input  wire logic signed [DATA_W-1:0] i_in_rdata,
    input  wire logic signed [DATA_W-1:0] i_out_rdata,
    output t_stk_ctl                      o_in_ctl,
    output t_stk_ctl                      o_out_ctl,
    output logic signed [DATA_W-1:0]      o_in_wdata,
    output logic signed [DATA_W-1:0]      o_out_wdata,
    output logic                          o_busy,
    output logic                          o_done,
    output t_rsp                          o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_pend,  n_pend;
    logic   r_done,  n_done;
    t_rsp   r_rsp,   n_rsp;

    logic in_empty, in_full, out_empty;

    assign in_empty  = (i_in_count == '0);
    assign in_full   = (i_in_count == CNT_W'(STACK_DEPTH));
    assign out_empty = (i_out_count == '0);

    // Write data paths: request value into the input stack, read data across
    assign o_in_wdata  = i_req.value;
    assign o_out_wdata = i_in_rdata;

    // Next-state and stack control
    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        o_in_ctl  = '0;
        o_out_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.command == CMD_PUSH) begin
                        n_done = 1'b1;
                        if (in_full) begin
                            n_rsp = '{data: '0, status: ST_FULL};
                        end else begin
                            o_in_ctl.push = 1'b1;
                            n_rsp = '{data: '0, status: ST_OK};
                        end
                    end else if (!out_empty) begin
                        o_out_ctl.pop = 1'b1;
                        n_state       = S_POP_WAIT;
                    end else if (!in_empty) begin
                        n_pend  = 1'b0;
                        n_state = S_XFER;
                    end else begin
                        n_done = 1'b1;
                        n_rsp  = '{data: '0, status: ST_EMPTY};
                    end
                end
            end
            S_XFER: begin
                // read top of input stack; write last read word to output stack
                o_in_ctl.pop   = !in_empty;
                o_out_ctl.push = r_pend;
                n_pend         = !in_empty;
                if (in_empty && !r_pend) begin
                    o_out_ctl.pop = 1'b1;
                    n_state       = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_done  = 1'b1;
                n_rsp   = '{data: i_out_rdata, status: ST_OK};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_rsp <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Checks
    a_out_push_in_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ctl.push |-> (r_state == S_XFER))
        else $error("output stack written outside transfer");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ctl.push |-> (i_out_count != CNT_W'(STACK_DEPTH)))
        else $error("output stack overflow");

    a_in_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ctl.pop |-> !in_empty)
        else $error("input stack underflow");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT) |=> r_done)
        else $error("pop finished without a result");

endmodule

`default_nettype wire
